// ----- hw/rtl/fwms_pkg.sv -----
// ----------------------------------------------------------------------------
// fwms_pkg
// Shared types and constants of the circular queue with membership search.
// ----------------------------------------------------------------------------
package fwms_pkg;

  localparam int unsigned DefaultQueueDepth = 16;
  localparam int unsigned DefaultEntryBytes = 8;

  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ValueW  = 64;

  // request codes
  localparam logic [ReqW-1:0] REQ_PUSH   = 2'd0;
  localparam logic [ReqW-1:0] REQ_POP    = 2'd1;
  localparam logic [ReqW-1:0] REQ_SEARCH = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_SCAN,
    ST_RESULT
  } state_e;

endpackage

// ----- hw/rtl/fwms_ram.sv -----
// ----------------------------------------------------------------------------
// fwms_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fwms_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/fifo_with_membership_search.sv -----
// ----------------------------------------------------------------------------
// fifo_with_membership_search
// Circular queue of short string entries with push, pop and membership search.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (req_type_i, entry_value_i) is taken when in_valid_i is
//   high and in_stall_o is low; every request yields exactly one result word
//   (status_o, popped_value_o, found_o) on out_valid_o / out_stall_i.
//   Entries are kept as strings: bytes after the first zero byte, or past
//   EntryBytes bytes, are cleared before storing and comparing.
//   Requests are handled one at a time. Push and rejected requests go straight
//   to the result register; a pop first reads its slot; a search reads at most
//   QueueDepth slots from the head and stops at the first hit. The single RAM
//   port sets the search rate: one slot read per cycle, compared in the next.
//   The result sits in an output register, so a stalled receiver only holds
//   the block once the next result is ready to move there.
//   Reset empties the queue (head, tail, count to zero) and drops any result
//   not yet taken; the slot RAM is not cleared, as only written slots are read.
// ----------------------------------------------------------------------------
module fifo_with_membership_search #(
  parameter int unsigned QueueDepth = fwms_pkg::DefaultQueueDepth,
  parameter int unsigned EntryBytes = fwms_pkg::DefaultEntryBytes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fwms_pkg::ReqW-1:0]    req_type_i,
  input  logic [fwms_pkg::ValueW-1:0]  entry_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fwms_pkg::StatusW-1:0] status_o,
  output logic [fwms_pkg::ValueW-1:0]  popped_value_o,
  output logic                         found_o
);

  localparam int unsigned EntryW = 8 * EntryBytes;
  localparam int unsigned IdxW   = $clog2(QueueDepth);
  localparam int unsigned CntW   = $clog2(QueueDepth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  fwms_pkg::state_e state_q, state_d;

  logic [IdxW-1:0]   head_q, head_d;
  logic [IdxW-1:0]   tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   scan_idx_q, scan_idx_d;
  logic [CntW-1:0]   issued_q, issued_d;
  logic [CntW-1:0]   cmp_q, cmp_d;
  logic              rd_vld_q, rd_vld_d;
  logic [EntryW-1:0] key_q, key_d;

  logic [fwms_pkg::StatusW-1:0] res_status_q, res_status_d;
  logic [fwms_pkg::ValueW-1:0]  res_popped_q, res_popped_d;
  logic                         res_found_q, res_found_d;

  logic                         out_valid_q, out_valid_d;
  logic [fwms_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic [fwms_pkg::ValueW-1:0]  out_popped_q, out_popped_d;
  logic                         out_found_q, out_found_d;

  logic              ram_we;
  logic [IdxW-1:0]   ram_addr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  logic              in_accept;
  logic              out_free;
  logic              q_full;
  logic              q_empty;
  logic              scan_hit;
  logic              scan_last;
  logic [CntW-1:0]   cmp_next;
  logic [EntryW-1:0] key_norm;
  logic              keep;
  logic [7:0]        byte_val;

  assign in_stall_o = (state_q != fwms_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign q_full     = (count_q == FullCnt);
  assign q_empty    = (count_q == '0);
  assign cmp_next   = cmp_q + CntW'(1);
  assign scan_hit   = rd_vld_q && (ram_rdata == key_q);
  assign scan_last  = rd_vld_q && (cmp_next == count_q);

  // string semantics: stop at the first zero byte
  always_comb begin
    keep     = 1'b1;
    byte_val = '0;
    key_norm = '0;
    for (int unsigned b = 0; b < EntryBytes; b++) begin
      byte_val = entry_value_i[8*b +: 8];
      if (byte_val == 8'd0) begin
        keep = 1'b0;
      end
      key_norm[8*b +: 8] = keep ? byte_val : 8'd0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fwms_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (req_type_i)
            fwms_pkg::REQ_POP:    state_d = q_empty ? fwms_pkg::ST_RESULT
                                                    : fwms_pkg::ST_POP_RD;
            fwms_pkg::REQ_SEARCH: state_d = q_empty ? fwms_pkg::ST_RESULT
                                                    : fwms_pkg::ST_SCAN;
            default:              state_d = fwms_pkg::ST_RESULT;
          endcase
        end
      end
      fwms_pkg::ST_POP_RD: state_d = fwms_pkg::ST_RESULT;
      fwms_pkg::ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_d = fwms_pkg::ST_RESULT;
        end
      end
      fwms_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = fwms_pkg::ST_IDLE;
        end
      end
      default: state_d = fwms_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control; only one request is in flight, so a slot is
  // never read and written in the same cycle
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    scan_idx_d   = scan_idx_q;
    issued_d     = issued_q;
    cmp_d        = cmp_q;
    rd_vld_d     = 1'b0;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_popped_d = res_popped_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_popped_d = out_popped_q;
    out_found_d  = out_found_q;
    ram_we       = 1'b0;
    ram_addr     = head_q;
    ram_wdata    = key_norm;

    unique case (state_q)
      fwms_pkg::ST_IDLE: begin
        if (in_accept) begin
          key_d        = key_norm;
          res_status_d = fwms_pkg::STATUS_OK;
          res_popped_d = '0;
          res_found_d  = 1'b0;
          unique case (req_type_i)
            fwms_pkg::REQ_PUSH: begin
              if (q_full) begin
                res_status_d = fwms_pkg::STATUS_FULL;
              end else begin
                ram_we   = 1'b1;
                ram_addr = tail_q;
                tail_d   = next_idx(tail_q);
                count_d  = count_q + CntW'(1);
              end
            end
            fwms_pkg::REQ_POP: begin
              if (q_empty) begin
                res_status_d = fwms_pkg::STATUS_EMPTY;
              end else begin
                ram_addr = head_q;
                head_d   = next_idx(head_q);
                count_d  = count_q - CntW'(1);
              end
            end
            fwms_pkg::REQ_SEARCH: begin
              if (!q_empty) begin
                ram_addr   = head_q;
                scan_idx_d = next_idx(head_q);
                issued_d   = CntW'(1);
                cmp_d      = '0;
                rd_vld_d   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      fwms_pkg::ST_POP_RD: begin
        res_popped_d = fwms_pkg::ValueW'(ram_rdata);
      end
      fwms_pkg::ST_SCAN: begin
        // compare the slot read last cycle while the next one is read
        if (scan_hit) begin
          res_found_d = 1'b1;
        end else if (rd_vld_q) begin
          cmp_d = cmp_next;
        end
        if (issued_q != count_q) begin
          ram_addr   = scan_idx_q;
          scan_idx_d = next_idx(scan_idx_q);
          issued_d   = issued_q + CntW'(1);
          rd_vld_d   = 1'b1;
        end
      end
      fwms_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_popped_d = res_popped_q;
          out_found_d  = res_found_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fwms_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      scan_idx_q  <= '0;
      issued_q    <= '0;
      cmp_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      issued_q    <= issued_d;
      cmp_q       <= cmp_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_popped_q <= res_popped_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_popped_q <= out_popped_d;
    out_found_q  <= out_found_d;
  end

  fwms_ram #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign popped_value_o = out_popped_q;
  assign found_o        = out_found_q;

endmodule

// ----- hw/rtl/fwms_chk.sv -----
// ----------------------------------------------------------------------------
// fwms_chk
// Port-level checks of the queue's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fwms_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [fwms_pkg::ReqW-1:0]    req_type_i,
  input logic [fwms_pkg::ValueW-1:0]  entry_value_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [fwms_pkg::StatusW-1:0] status_o,
  input logic [fwms_pkg::ValueW-1:0]  popped_value_o,
  input logic                         found_o
);

  // a hit is only reported by a search, which never fails
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == fwms_pkg::STATUS_OK)
    else $error("found set with a non-ok status");

  // a popped entry only comes with an ok status and no hit
  a_pop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (popped_value_o != '0) |->
      (status_o == fwms_pkg::STATUS_OK) && !found_o)
    else $error("popped value on a failed or search result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == fwms_pkg::STATUS_OK) ||
                    (status_o == fwms_pkg::STATUS_FULL) ||
                    (status_o == fwms_pkg::STATUS_EMPTY))
    else $error("unknown status code");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(status_o) && $stable(popped_value_o) && $stable(found_o))
    else $error("stalled result word changed");

endmodule

bind fifo_with_membership_search fwms_chk u_fwms_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .req_type_i     (req_type_i),
  .entry_value_i  (entry_value_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .popped_value_o (popped_value_o),
  .found_o        (found_o)
);

// ----- dv/fifo_with_membership_search_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_membership_search_test
// Drives push, pop, search and unused request words into the string queue under
// random idling on both sides. A queue model in the bench predicts every result
// word, and each result is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module fifo_with_membership_search_test;

  localparam int unsigned QueueDepth = fwms_pkg::DefaultQueueDepth;
  localparam int unsigned EntryBytes = fwms_pkg::DefaultEntryBytes;

  // request code that the block answers without touching the queue
  localparam logic [fwms_pkg::ReqW-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [fwms_pkg::StatusW-1:0] status;
    logic [fwms_pkg::ValueW-1:0]  popped_value;
    logic                         found;
  } queue_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid;
  logic                         in_stall;
  logic [fwms_pkg::ReqW-1:0]    req_type;
  logic [fwms_pkg::ValueW-1:0]  entry_value;
  logic                         out_valid;
  logic                         out_stall;
  logic [fwms_pkg::StatusW-1:0] status;
  logic [fwms_pkg::ValueW-1:0]  popped_value;
  logic                         found;

  logic [fwms_pkg::ValueW-1:0] queued_entries[$];
  queue_result_t               pending_results[$];
  int                          mismatch_count = 0;
  int                          send_gap_max   = 19;
  int                          stall_gap_max  = 19;

  fifo_with_membership_search #(
    .QueueDepth(QueueDepth),
    .EntryBytes(EntryBytes)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .entry_value_i (entry_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .popped_value_o(popped_value),
    .found_o       (found)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // keep bytes up to the first zero byte, at most EntryBytes of them
  function automatic logic [fwms_pkg::ValueW-1:0] normalize_string(
      input logic [fwms_pkg::ValueW-1:0] value);
    logic [fwms_pkg::ValueW-1:0] r;
    bit                          ended;
    r = '0;
    ended = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (b >= EntryBytes || value[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[8*b +: 8] = value[8*b +: 8];
    end
    return r;
  endfunction

  function automatic queue_result_t apply_request(input logic [fwms_pkg::ReqW-1:0] req,
                                                  input logic [fwms_pkg::ValueW-1:0] value);
    queue_result_t               r;
    logic [fwms_pkg::ValueW-1:0] key;
    r.status = fwms_pkg::STATUS_OK;
    r.popped_value = '0;
    r.found = 1'b0;
    key = normalize_string(value);
    case (req)
      fwms_pkg::REQ_PUSH: begin
        if (queued_entries.size() >= QueueDepth) r.status = fwms_pkg::STATUS_FULL;
        else queued_entries.push_back(key);
      end
      fwms_pkg::REQ_POP: begin
        if (queued_entries.size() == 0) r.status = fwms_pkg::STATUS_EMPTY;
        else r.popped_value = queued_entries.pop_front();
      end
      fwms_pkg::REQ_SEARCH: begin
        foreach (queued_entries[i]) if (queued_entries[i] == key) r.found = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // random string of random length, sometimes a raw 64-bit pattern
  function automatic logic [fwms_pkg::ValueW-1:0] random_entry();
    logic [fwms_pkg::ValueW-1:0] v;
    int                          len;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) return v;
    len = $urandom_range(0, 8);
    for (int b = 0; b < 8; b++) begin
      if (b < len && v[8*b +: 8] == 8'h00) v[8*b +: 8] = 8'h41;
      if (b == len) v[8*b +: 8] = 8'h00;
    end
    return v;
  endfunction

  // same string, random junk after its terminator
  function automatic logic [fwms_pkg::ValueW-1:0] garble_tail(
      input logic [fwms_pkg::ValueW-1:0] value);
    logic [fwms_pkg::ValueW-1:0] v;
    logic [fwms_pkg::ValueW-1:0] noise;
    bit                          ended;
    v = value;
    noise = {$urandom, $urandom};
    ended = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (ended || b >= EntryBytes) v[8*b +: 8] = noise[8*b +: 8];
      else if (v[8*b +: 8] == 8'h00) ended = 1'b1;
    end
    return v;
  endfunction

  // called just after a rising edge; returns just after the accepting edge
  task automatic issue_request(input logic [fwms_pkg::ReqW-1:0]   req,
                               input logic [fwms_pkg::ValueW-1:0] value);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    entry_value <= value;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_results.push_back(apply_request(req, value));
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_queue();
    issue_request(fwms_pkg::REQ_POP, random_entry());
    issue_request(fwms_pkg::REQ_SEARCH, random_entry());
    issue_request(REQ_UNUSED, random_entry());
  endtask

  task automatic test_entry_shapes();
    issue_request(fwms_pkg::REQ_PUSH, '0);
    issue_request(fwms_pkg::REQ_PUSH, '1);
    // zero byte in the middle, junk after it is dropped
    issue_request(fwms_pkg::REQ_PUSH, 64'h6a6b_6c00_6d6e_6f70);
    issue_request(fwms_pkg::REQ_SEARCH, 64'hffee_dd00_6d6e_6f70);
    issue_request(fwms_pkg::REQ_SEARCH, '0);
    issue_request(fwms_pkg::REQ_SEARCH, 64'h0000_0000_0000_7071);
    issue_request(REQ_UNUSED, '1);
    issue_request(fwms_pkg::REQ_POP, '1);
  endtask

  task automatic test_full_queue();
    while (queued_entries.size() < QueueDepth) begin
      issue_request(fwms_pkg::REQ_PUSH, random_entry());
    end
    issue_request(fwms_pkg::REQ_PUSH, random_entry());
    issue_request(fwms_pkg::REQ_SEARCH, garble_tail(queued_entries[QueueDepth-1]));
  endtask

  task automatic issue_random_request(input int push_pct, input int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      issue_request(fwms_pkg::REQ_PUSH, random_entry());
    end else if (roll < push_pct + pop_pct) begin
      issue_request(fwms_pkg::REQ_POP, {$urandom, $urandom});
    end else if ($urandom_range(0, 19) == 0) begin
      issue_request(REQ_UNUSED, {$urandom, $urandom});
    end else if (queued_entries.size() != 0 && $urandom_range(0, 1) == 0) begin
      issue_request(fwms_pkg::REQ_SEARCH,
                    garble_tail(queued_entries[$urandom_range(0, queued_entries.size()-1)]));
    end else begin
      issue_request(fwms_pkg::REQ_SEARCH, random_entry());
    end
  endtask

  // phases that lean toward filling, draining or searching the queue, or mix them
  task automatic test_random_traffic(input int word_count);
    int sent;
    int phase_len;
    int push_pct;
    int pop_pct;
    sent = 0;
    while (sent < word_count) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0:       begin push_pct = 75; pop_pct = 10; end
        1:       begin push_pct = 10; pop_pct = 75; end
        2:       begin push_pct = 40; pop_pct = 35; end
        default: begin push_pct = 25; pop_pct = 20; end
      endcase
      send_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 19;
      stall_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      repeat (phase_len) begin
        issue_random_request(push_pct, pop_pct);
        sent++;
      end
    end
    send_gap_max  = 19;
    stall_gap_max = 19;
  endtask

  initial begin : result_checker
    int            hold;
    queue_result_t want;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word: status %0d popped %h found %0d",
                   $time, status, popped_value, found);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatch_count++;
          end
          if (popped_value !== want.popped_value) begin
            $display("%0t: popped_value expected %h actual %h",
                     $time, want.popped_value, popped_value);
            mismatch_count++;
          end
          if (found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, found);
            mismatch_count++;
          end
        end
        hold = $urandom_range(0, stall_gap_max);
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid    <= 1'b0;
    req_type    <= fwms_pkg::REQ_PUSH;
    entry_value <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_entry_shapes();
    test_full_queue();
    wait_until_drained();
    test_random_traffic(900);
    wait_until_drained();
    test_random_traffic(900);

    wait_until_drained();
    repeat (QueueDepth + 8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
